// ===== design/iso2022_cn_to_euc_cn_decoder_top_macros.svh =====
// Assertion macros shared by the decoder modules.
`ifndef ISO2022_CN_TO_EUC_CN_DECODER_TOP_MACROS_SVH
`define ISO2022_CN_TO_EUC_CN_DECODER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define I2CN_ASSERT_NOW(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define I2CN_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/i2cn_pkg.sv =====
// Types, character codes and helpers shared by the ISO-2022-CN decoder modules.
`default_nettype none

package i2cn_pkg;

    localparam int RUN_MAX     = 4;
    localparam int IDX_W       = $clog2(RUN_MAX);
    localparam int CNT_W       = $clog2(RUN_MAX + 1);
    localparam int Q_DEPTH_DEF = 2;

    localparam logic [7:0] CH_ESC    = 8'h1b;
    localparam logic [7:0] CH_SO     = 8'h0e;
    localparam logic [7:0] CH_SI     = 8'h0f;
    localparam logic [7:0] CH_HIGH   = 8'h80;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_A      = 8'h41;

    localparam logic OP_DATA    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    typedef enum logic [2:0] {
        ST_ASCII            = 3'd0,
        ST_ESC              = 3'd1,
        ST_ESC_DOLLAR       = 3'd2,
        ST_ESC_DOLLAR_PAREN = 3'd3,
        ST_SHIFT_IN         = 3'd4,
        ST_SHIFT_OUT        = 3'd5,
        ST_PAIR             = 3'd6
    } mode_t;

    // One input byte's worth of output: up to RUN_MAX bytes, count of them valid.
    typedef struct packed {
        logic [RUN_MAX-1:0][7:0] data;
        logic [CNT_W-1:0]        count;
    } run_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

    // Byte at a given position of a held escape prefix (ESC $ ).
    function automatic logic [7:0] prefix_byte(input logic [IDX_W-1:0] pos);
        logic [7:0] b;
        unique case (pos)
            IDX_W'(1): b = CH_DOLLAR;
            IDX_W'(2): b = CH_RPAREN;
            default:   b = CH_ESC;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== design/i2cn_front.sv =====
// Front end: accepts input beats, tracks the shift state and builds output runs.
`default_nettype none

`include "iso2022_cn_to_euc_cn_decoder_top_macros.svh"

module i2cn_front
    import i2cn_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       operation,
    input  wire logic [7:0] byte_in,
    input  wire q_stat_t    q_stat,
    output logic            push,
    output run_t            push_run
);

    mode_t            state_reg, state_next;
    logic [7:0]       held_reg, held_next;
    logic             in_fire;
    logic             brk;
    logic [IDX_W-1:0] prefix_len;
    run_t             run;

    assign in_ready = !q_stat.full;
    assign in_fire  = in_valid && in_ready;
    assign push     = in_fire && (run.count != '0);
    assign push_run = run;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ASCII;
        end
        else if (in_fire)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            held_reg <= held_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        held_next  = held_reg;
        run        = '0;
        brk        = 1'b0;
        prefix_len = '0;

        unique case (state_reg)
            ST_ESC:
            begin
                if (byte_in == CH_DOLLAR)
                begin
                    state_next = ST_ESC_DOLLAR;
                end
                else
                begin
                    brk        = 1'b1;
                    prefix_len = IDX_W'(1);
                end
            end
            ST_ESC_DOLLAR:
            begin
                if (byte_in == CH_RPAREN)
                begin
                    state_next = ST_ESC_DOLLAR_PAREN;
                end
                else
                begin
                    brk        = 1'b1;
                    prefix_len = IDX_W'(2);
                end
            end
            ST_ESC_DOLLAR_PAREN:
            begin
                if (byte_in == CH_A)
                begin
                    state_next = ST_SHIFT_IN;
                end
                else
                begin
                    brk        = 1'b1;
                    prefix_len = IDX_W'(3);
                end
            end
            ST_SHIFT_IN:
            begin
                if (byte_in == CH_SO)
                begin
                    state_next = ST_SHIFT_OUT;
                end
                else
                begin
                    run.data[0] = byte_in;
                    run.count   = CNT_W'(1);
                end
            end
            ST_SHIFT_OUT:
            begin
                if (byte_in == CH_SI)
                begin
                    state_next = ST_SHIFT_IN;
                end
                else
                begin
                    held_next  = byte_in;
                    state_next = ST_PAIR;
                end
            end
            ST_PAIR:
            begin
                // The second byte of a pair is taken as it stands, even SI.
                run.data[0] = held_reg | CH_HIGH;
                run.data[1] = byte_in | CH_HIGH;
                run.count   = CNT_W'(2);
                state_next  = ST_SHIFT_OUT;
            end
            default:
            begin
                brk = 1'b1;
            end
        endcase

        // A broken escape replays its held prefix, then the breaking byte is
        // treated as in ASCII mode: passed on, or the start of a new escape.
        if (brk)
        begin
            for (int i = 0; i < RUN_MAX; i++)
            begin
                run.data[i] = (IDX_W'(i) == prefix_len) ? byte_in
                                                        : prefix_byte(IDX_W'(i));
            end
            run.count  = CNT_W'(prefix_len) + CNT_W'(byte_in != CH_ESC);
            state_next = (byte_in == CH_ESC) ? ST_ESC : ST_ASCII;
        end

        if (operation == OP_RESTART)
        begin
            state_next = ST_ASCII;
            held_next  = held_reg;
            run        = '0;
        end
    end

    `I2CN_ASSERT_NEXT(a_restart_to_ascii, clk, rst_n,
        in_fire && (operation == OP_RESTART), state_reg == ST_ASCII,
        "restart did not return the decoder to ASCII mode")
    `I2CN_ASSERT_NOW(a_run_length, clk, rst_n,
        push, (push_run.count != '0) && (push_run.count <= CNT_W'(RUN_MAX)),
        "run pushed with an impossible byte count")

endmodule

`default_nettype wire

// ===== design/i2cn_queue.sv =====
// Run queue between the front end and the output sequencer.
`default_nettype none

`include "iso2022_cn_to_euc_cn_decoder_top_macros.svh"

module i2cn_queue
    import i2cn_pkg::*;
#(
    parameter int DEPTH = Q_DEPTH_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire run_t push_run,
    input  wire logic pop,
    output run_t      head,
    output q_stat_t   q_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);

    run_t              entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [FILL_W-1:0] fill_reg;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] n;
        n = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
        return n;
    endfunction

    assign head         = entry_reg[rd_ptr_reg];
    assign q_stat.empty = (fill_reg == '0);
    assign q_stat.full  = (fill_reg == FILL_W'(DEPTH));

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_run;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + FILL_W'(1);
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - FILL_W'(1);
            end
        end
    end

    `I2CN_ASSERT_NOW(a_no_overflow, clk, rst_n, push, !q_stat.full,
        "run pushed into a full queue")
    `I2CN_ASSERT_NOW(a_no_underflow, clk, rst_n, pop, !q_stat.empty,
        "run popped from an empty queue")

endmodule

`default_nettype wire

// ===== design/i2cn_back.sv =====
// Output sequencer: plays each queued run out one byte per beat.
`default_nettype none

`include "iso2022_cn_to_euc_cn_decoder_top_macros.svh"

module i2cn_back
    import i2cn_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire run_t    head,
    input  wire q_stat_t q_stat,
    output logic         pop,
    output logic         out_valid,
    input  wire logic    out_ready,
    output logic [7:0]   byte_out,
    output logic         last_of_run
);

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             out_fire;

    assign out_valid   = !q_stat.empty;
    assign byte_out    = head.data[idx_reg];
    assign last_of_run = (CNT_W'(idx_reg) == head.count - CNT_W'(1));
    assign out_fire    = out_valid && out_ready;
    assign pop         = out_fire && last_of_run;

    always_comb
    begin
        idx_next = idx_reg;
        if (out_fire)
        begin
            idx_next = last_of_run ? '0 : idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

    `I2CN_ASSERT_NOW(a_idle_index_zero, clk, rst_n, q_stat.empty, idx_reg == '0,
        "byte index not at the start of a run while the queue is empty")
    `I2CN_ASSERT_NEXT(a_index_advances, clk, rst_n, out_fire && !last_of_run,
        idx_reg == $past(idx_reg) + IDX_W'(1),
        "byte index did not advance within a run")

endmodule

`default_nettype wire

// ===== design/iso2022_cn_to_euc_cn_decoder_top.sv =====
// Top level of the ISO-2022-CN (GB2312) to EUC-CN stream decoder.
`default_nettype none

// Converts a 7-bit ISO-2022-CN byte stream carrying GB2312 into EUC-CN, one
// input beat per cycle. Each input beat yields zero to four output beats;
// the last of them carries last_of_run. The front end takes an input beat
// every cycle as long as its run queue (QUEUE_DEPTH entries) has room; each
// run is registered into the queue and offered once the runs ahead of it
// have left. While out_ready is high, the output side delivers one byte per
// cycle, and sustained input rate is one beat per cycle if each beat yields
// at most one byte, and follows the output byte count otherwise.
// A restart beat returns the decoder to ASCII mode and produces no output.
module iso2022_cn_to_euc_cn_decoder_top
    import i2cn_pkg::*;
#(
    parameter int QUEUE_DEPTH = Q_DEPTH_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       operation,
    input  wire logic [7:0] byte_in,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      byte_out,
    output logic            last_of_run
);

    q_stat_t q_stat;
    logic    push;
    logic    pop;
    run_t    push_run;
    run_t    head;

    i2cn_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .operation(operation),
        .byte_in  (byte_in),
        .q_stat   (q_stat),
        .push     (push),
        .push_run (push_run)
    );

    i2cn_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_run(push_run),
        .pop     (pop),
        .head    (head),
        .q_stat  (q_stat)
    );

    i2cn_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .q_stat     (q_stat),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .byte_out   (byte_out),
        .last_of_run(last_of_run)
    );

endmodule

`default_nettype wire
